>>> rtl/bpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpt_pkg;

  localparam int NUM_BUTTONS_DEF = 32;

  localparam int LEVEL_W = 32;
  localparam int BTN_W   = 5;
  localparam int PRESS_W = 14;
  localparam int REL_W   = 16;
  localparam int THR_W   = 16;
  localparam int PER_W   = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PRESSED_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION   = 2'd2;

  localparam logic [PRESS_W-1:0] PRESS_MAX  = 14'd10000;
  localparam logic [PRESS_W-1:0] PRESS_FOLD = 14'd5000;

  // One request as it travels from the front end to the execution side.
  typedef struct packed {
    logic               is_tick;
    logic [LEVEL_W-1:0] levels;
    logic [BTN_W-1:0]   btn;
    logic               in_range;
    logic [THR_W-1:0]   thr;
    logic [PER_W-1:0]   per;
  } req_t;

  typedef struct packed {
    logic [PRESS_W-1:0] press;
    logic [REL_W-1:0]   rel;
  } cnt_t;

endpackage

`default_nettype wire

>>> rtl/bpt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/bpt_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bpt_front #(
  parameter int NUM_BUTTONS = bpt_pkg::NUM_BUTTONS_DEF
) (
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_req_type,
  input  wire logic [bpt_pkg::LEVEL_W-1:0]  in_levels,
  input  wire logic [bpt_pkg::BTN_W-1:0]    in_button_index,
  input  wire logic [bpt_pkg::THR_W-1:0]    in_hold_threshold,
  input  wire logic [bpt_pkg::PER_W-1:0]    in_hold_period,
  input  wire logic [1:0]                   orientation,
  input  wire logic                         q_full,
  output logic                              q_push,
  output bpt_pkg::req_t                     q_data
);

  import bpt_pkg::*;

  logic [BTN_W-1:0] mapped;
  logic [1:0]       rot;

  // The two joysticks occupy buttons 0 to 3 and 5 to 8; their directions turn with the display.
  always_comb begin
    mapped = in_button_index;
    rot    = 2'd0;
    if (in_button_index <= BTN_W'(3)) begin
      rot    = in_button_index[1:0] + 2'd1 - orientation;
      mapped = BTN_W'(rot);
    end else if (in_button_index >= BTN_W'(5) && in_button_index <= BTN_W'(8)) begin
      rot    = in_button_index[1:0] - 2'd1 + 2'd1 - orientation;
      mapped = BTN_W'(5) + BTN_W'(rot);
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_data.is_tick  = !in_req_type;
    q_data.levels   = in_levels;
    q_data.btn      = mapped;
    q_data.in_range = {2'b00, in_button_index} < 7'(NUM_BUTTONS);
    q_data.thr      = in_hold_threshold;
    q_data.per      = in_hold_period;
  end

endmodule

`default_nettype wire

>>> rtl/bpt_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module bpt_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire bpt_pkg::req_t push_data,
  output logic               full,
  input  wire logic          pop,
  output bpt_pkg::req_t      pop_data,
  output logic               empty
);

  import bpt_pkg::*;

  req_t       ent_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign full     = cnt_r == 2'd2;
  assign empty    = cnt_r == 2'd0;
  assign pop_data = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bpt_back.sv
`timescale 1ns / 1ps
`default_nettype none

module bpt_back #(
  parameter int NUM_BUTTONS = bpt_pkg::NUM_BUTTONS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_empty,
  input  wire bpt_pkg::req_t               q_data,
  output logic                             q_pop,
  input  wire logic                        pressed_level,
  input  wire logic [bpt_pkg::REL_W-1:0]   release_limit,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [bpt_pkg::PRESS_W-1:0] out_press_time,
  output logic      [bpt_pkg::REL_W-1:0]   out_release_time,
  output logic                             out_hold_event
);

  import bpt_pkg::*;

  localparam int IDX_W = $clog2(NUM_BUTTONS);
  localparam int SLOTS = 1 << IDX_W;
  localparam int BIT_W = $clog2(PRESS_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_QRD,
    ST_QCAP,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t             state_r,    state_nxt;
  req_t               cur_r,      cur_nxt;
  logic [IDX_W-1:0]   cnt_r,      cnt_nxt;
  logic               wb_vld_r,   wb_vld_nxt;
  logic [IDX_W-1:0]   wb_idx_r,   wb_idx_nxt;
  logic [SLOTS-1:0]   vld_r,      vld_nxt;
  logic [PRESS_W-1:0] press_r,    press_nxt;
  logic [REL_W-1:0]   rel_r,      rel_nxt;
  logic [PRESS_W-1:0] dvd_r,      dvd_nxt;
  logic [PER_W-1:0]   rem_r,      rem_nxt;
  logic [BIT_W-1:0]   bit_r,      bit_nxt;
  logic               hold_r,     hold_nxt;
  logic               out_vld_r,  out_vld_nxt;
  logic [PRESS_W-1:0] out_press_r, out_press_nxt;
  logic [REL_W-1:0]   out_rel_r,  out_rel_nxt;
  logic               out_hold_r, out_hold_nxt;

  logic               ram_we;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  cnt_t               ram_rdata;
  cnt_t               old_cnt;
  cnt_t               new_cnt;
  logic [IDX_W-1:0]   q_idx;
  logic [SLOTS-1:0]   lvl_vec;
  logic               lvl;
  logic [PRESS_W-1:0] p_inc;
  logic [REL_W-1:0]   r_inc;
  logic               rd_ok;
  logic [PRESS_W-1:0] press_c;
  logic [REL_W-1:0]   rel_c;
  logic [THR_W-1:0]   diff;
  logic [PER_W:0]     rem_t;
  logic [PER_W:0]     rem_s;
  logic               load;

  bpt_ram #(
    .WIDTH ($bits(cnt_t)),
    .DEPTH (NUM_BUTTONS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wb_idx_r),
    .wdata (new_cnt),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  for (genvar i = 0; i < SLOTS; i++) begin : g_lvl
    if (i < LEVEL_W) begin : g_pin
      assign lvl_vec[i] = cur_r.levels[i];
    end else begin : g_none
      assign lvl_vec[i] = 1'b0;
    end
  end

  assign q_idx     = IDX_W'({2'b00, cur_r.btn});
  assign q_pop     = (state_r == ST_IDLE) && !q_empty && !wb_vld_r;
  assign ram_re    = (state_r == ST_TICK) || (state_r == ST_QRD);
  assign ram_raddr = (state_r == ST_TICK) ? cnt_r : q_idx;
  assign ram_we    = wb_vld_r;
  assign lvl       = lvl_vec[wb_idx_r];
  assign load      = (state_r == ST_DONE) && (!out_vld_r || out_ready);

  // Counter update for the entry read in the previous cycle of the tick sweep.
  always_comb begin
    old_cnt = vld_r[wb_idx_r] ? ram_rdata : '0;
    new_cnt = old_cnt;
    p_inc   = old_cnt.press + PRESS_W'(1);
    r_inc   = old_cnt.rel + REL_W'(1);
    if (lvl == pressed_level) begin
      new_cnt.press = (p_inc > PRESS_MAX) ? PRESS_FOLD : p_inc;
      new_cnt.rel   = '0;
    end else begin
      if (old_cnt.press != '0) begin
        new_cnt.rel = REL_W'(1);
      end else if (old_cnt.rel != '0) begin
        new_cnt.rel = (r_inc > release_limit) ? '0 : r_inc;
      end
      new_cnt.press = '0;
    end
  end

  always_comb begin
    rd_ok   = cur_r.in_range && vld_r[q_idx];
    press_c = rd_ok ? ram_rdata.press : '0;
    rel_c   = rd_ok ? ram_rdata.rel : '0;
    diff    = {2'b00, press_c} - cur_r.thr;
    rem_t   = {rem_r, dvd_r[PRESS_W-1]};
    rem_s   = (rem_t >= {1'b0, cur_r.per}) ? rem_t - {1'b0, cur_r.per} : rem_t;
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    cnt_nxt       = cnt_r;
    wb_vld_nxt    = 1'b0;
    wb_idx_nxt    = cnt_r;
    vld_nxt       = vld_r;
    press_nxt     = press_r;
    rel_nxt       = rel_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    bit_nxt       = bit_r;
    hold_nxt      = hold_r;
    out_vld_nxt   = out_vld_r && !out_ready;
    out_press_nxt = out_press_r;
    out_rel_nxt   = out_rel_r;
    out_hold_nxt  = out_hold_r;

    if (wb_vld_r) begin
      vld_nxt[wb_idx_r] = 1'b1;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          cur_nxt   = q_data;
          cnt_nxt   = '0;
          state_nxt = q_data.is_tick ? ST_TICK : ST_QRD;
        end
      end
      ST_TICK: begin
        wb_vld_nxt = 1'b1;
        cnt_nxt    = cnt_r + IDX_W'(1);
        if (cnt_r == IDX_W'(NUM_BUTTONS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_QRD: begin
        state_nxt = ST_QCAP;
      end
      ST_QCAP: begin
        press_nxt = press_c;
        rel_nxt   = rel_c;
        dvd_nxt   = diff[PRESS_W-1:0];
        rem_nxt   = '0;
        bit_nxt   = BIT_W'(PRESS_W - 1);
        hold_nxt  = 1'b0;
        if (cur_r.per != '0 && {2'b00, press_c} > cur_r.thr) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DIV: begin
        rem_nxt = rem_s[PER_W-1:0];
        dvd_nxt = {dvd_r[PRESS_W-2:0], 1'b0};
        bit_nxt = bit_r - BIT_W'(1);
        if (bit_r == '0) begin
          hold_nxt  = rem_s == '0;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load) begin
          out_vld_nxt   = 1'b1;
          out_press_nxt = press_r;
          out_rel_nxt   = rel_r;
          out_hold_nxt  = hold_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      wb_vld_r  <= 1'b0;
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      wb_vld_r  <= wb_vld_nxt;
      vld_r     <= vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
    cur_r       <= cur_nxt;
    cnt_r       <= cnt_nxt;
    wb_idx_r    <= wb_idx_nxt;
    press_r     <= press_nxt;
    rel_r       <= rel_nxt;
    dvd_r       <= dvd_nxt;
    rem_r       <= rem_nxt;
    bit_r       <= bit_nxt;
    hold_r      <= hold_nxt;
    out_press_r <= out_press_nxt;
    out_rel_r   <= out_rel_nxt;
    out_hold_r  <= out_hold_nxt;
  end

  assign out_valid        = out_vld_r;
  assign out_press_time   = out_press_r;
  assign out_release_time = out_rel_r;
  assign out_hold_event   = out_hold_r;

  a_wb_follows_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    wb_vld_r |-> $past(state_r) == ST_TICK)
    else $error("write-back without a preceding sweep read");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> ram_raddr != wb_idx_r)
    else $error("counter read and write hit the same entry");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> rem_r < cur_r.per)
    else $error("partial remainder not below the period");

endmodule

`default_nettype wire

>>> rtl/button_press_timer_autorepeat.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    req_type, levels, button_index, hold_threshold,
//                                           hold_period
// out_      output     out_valid/out_ready  press_time, release_time, hold_event
// cfg_      input      cfg_we               cfg_index, cfg_wdata
//
// A tick sweeps the counter RAM one button per cycle, with read and write-back
// overlapping. A query reads the counters and, when the press time exceeds the
// threshold and the period is non-zero, also works out a bit-serial remainder.
// Reset is synchronous and active low; per-entry valid flags make every counter read
// as zero afterwards, so there is no clearing pass. A two-entry request queue lets
// input be taken while the back end works, and a full result register stalls it.

module button_press_timer_autorepeat #(
  parameter int NUM_BUTTONS = bpt_pkg::NUM_BUTTONS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_req_type,
  input  wire logic [bpt_pkg::LEVEL_W-1:0]    in_levels,
  input  wire logic [bpt_pkg::BTN_W-1:0]      in_button_index,
  input  wire logic [bpt_pkg::THR_W-1:0]      in_hold_threshold,
  input  wire logic [bpt_pkg::PER_W-1:0]      in_hold_period,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [bpt_pkg::PRESS_W-1:0]    out_press_time,
  output logic      [bpt_pkg::REL_W-1:0]      out_release_time,
  output logic                                out_hold_event,
  input  wire logic                           cfg_we,
  input  wire logic [bpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bpt_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import bpt_pkg::*;

  logic             pressed_level_r, pressed_level_nxt;
  logic [REL_W-1:0] release_limit_r, release_limit_nxt;
  logic [1:0]       orientation_r,   orientation_nxt;

  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  req_t q_in;
  req_t q_out;

  always_comb begin
    pressed_level_nxt = pressed_level_r;
    release_limit_nxt = release_limit_r;
    orientation_nxt   = orientation_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_PRESSED_LEVEL: pressed_level_nxt = cfg_wdata[0];
        REG_RELEASE_LIMIT: release_limit_nxt = cfg_wdata;
        REG_ORIENTATION:   orientation_nxt   = cfg_wdata[1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_level_r <= 1'b0;
      release_limit_r <= REL_W'(100);
      orientation_r   <= 2'd0;
    end else begin
      pressed_level_r <= pressed_level_nxt;
      release_limit_r <= release_limit_nxt;
      orientation_r   <= orientation_nxt;
    end
  end

  bpt_front #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_front (
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_levels         (in_levels),
    .in_button_index   (in_button_index),
    .in_hold_threshold (in_hold_threshold),
    .in_hold_period    (in_hold_period),
    .orientation       (orientation_r),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_data            (q_in)
  );

  bpt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  bpt_back #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_data           (q_out),
    .q_pop            (q_pop),
    .pressed_level    (pressed_level_r),
    .release_limit    (release_limit_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_press_time   (out_press_time),
    .out_release_time (out_release_time),
    .out_hold_event   (out_hold_event)
  );

endmodule

`default_nettype wire
